// ----- src/digipot_resistance_spi_writer_assert.svh -----
// Assertion macros used by the digital potentiometer writer checker.
`ifndef DIGIPOT_RESISTANCE_SPI_WRITER_ASSERT_SVH
`define DIGIPOT_RESISTANCE_SPI_WRITER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define DPSW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpsw assertion failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define DPSW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpsw assertion failed");

`endif

// ----- src/dpsw_pkg.sv -----
// Types and constants for the digital potentiometer wiper writer.
package dpsw_pkg;

  // Field widths.
  localparam int CODE_BITS  = 8;
  localparam int OHM_BITS   = 20;
  localparam int FRAME_BITS = CODE_BITS + 1;
  localparam int CNT_W      = $clog2(FRAME_BITS);
  localparam int STEP_W     = $clog2(CODE_BITS);
  // Dividend 510*(max-R)+max needs nine more bits than the ohm value, plus a carry.
  localparam int NUM_W      = OHM_BITS + CODE_BITS + 2;

  // Code values.
  localparam logic [CODE_BITS-1:0] CODE_FULL = {CODE_BITS{1'b1}};
  localparam logic [CODE_BITS-1:0] CODE_ZERO = '0;

  // Operation codes.
  localparam logic OP_RAW = 1'b0;
  localparam logic OP_SET = 1'b1;

  // Configuration register indexes.
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_OHMS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_OHMS = 1'b1;

  // Register reset values.
  localparam logic [OHM_BITS-1:0] MAX_OHMS_RESET = OHM_BITS'(20000);
  localparam logic [OHM_BITS-1:0] MIN_OHMS_RESET = '0;

  // Input beat.
  typedef struct packed {
    logic                 operation;
    logic [1:0]           channel;
    logic [CODE_BITS-1:0] raw_code;
    logic [OHM_BITS-1:0]  resistance;
  } in_beat_t;

  // Output beat, one per frame bit.
  typedef struct packed {
    logic                 serial_bit;
    logic                 frame_end;
    logic [CODE_BITS-1:0] code_sent;
    logic [OHM_BITS-1:0]  stored_ohms;
  } out_beat_t;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/dpsw_divider.sv -----
// Restoring divider producing one quotient bit per cycle for the ohms-to-code conversion.
module dpsw_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [dpsw_pkg::OHM_BITS-1:0]  diff,
  input  logic [dpsw_pkg::OHM_BITS-1:0]  top,
  output dpsw_pkg::div_stat_t            stat,
  output logic [dpsw_pkg::CODE_BITS-1:0] quotient
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [dpsw_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [dpsw_pkg::NUM_W-1:0]    rem_r, rem_nxt;
  logic [dpsw_pkg::NUM_W-1:0]    sdiv_r, sdiv_nxt;
  logic [dpsw_pkg::CODE_BITS-1:0] q_r, q_nxt;
  logic [dpsw_pkg::NUM_W-1:0]    diff_ext;
  logic [dpsw_pkg::NUM_W-1:0]    top_ext;
  logic                          ge;

  assign diff_ext = dpsw_pkg::NUM_W'(diff);
  assign top_ext  = dpsw_pkg::NUM_W'(top);
  assign ge       = (rem_r >= sdiv_r);

  // Load the dividend 510*diff + top and the divisor 2*top aligned to the top quotient bit,
  // then compare and subtract once per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    sdiv_nxt = sdiv_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = dpsw_pkg::STEP_W'(dpsw_pkg::CODE_BITS - 1);
      rem_nxt  = (diff_ext << (dpsw_pkg::CODE_BITS + 1)) - (diff_ext << 1) + top_ext;
      sdiv_nxt = top_ext << dpsw_pkg::CODE_BITS;
      q_nxt    = '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - sdiv_r;
      end
      q_nxt    = {q_r[dpsw_pkg::CODE_BITS-2:0], ge};
      sdiv_nxt = sdiv_r >> 1;
      step_nxt = step_r - dpsw_pkg::STEP_W'(1);
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    sdiv_r <= sdiv_nxt;
    q_r    <= q_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

// ----- src/digipot_resistance_spi_writer.sv -----
// Top level: command sequencer, resistance store and serial frame output of the wiper writer.
//
//   Port group  Direction  Handshake         Carries
//   in_*        input      in_valid/ready    operation, channel, raw code, resistance
//   out_*       output     out_valid/ready   one frame bit per beat, code, stored ohms
//   cfg_*       input      cfg_we only       max and min resistance registers
//
// A raw write or a clamped resistance is accepted and then sent as 9 output beats.
// An in-range resistance with a nonzero maximum first goes through the divider for its 8 quotient bits.
// Channel values above one are accepted and dropped.
// Reset (rst_n, synchronous) clears the stored resistances and loads the register defaults.
// A stalled out_ready holds the current bit; no new item is taken until the frame ends.
module digipot_resistance_spi_writer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dpsw_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dpsw_pkg::out_beat_t             out_data,
  input  logic                            cfg_we,
  input  logic [dpsw_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [dpsw_pkg::OHM_BITS-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [dpsw_pkg::OHM_BITS-1:0]   max_ohms_r, min_ohms_r;
  logic [dpsw_pkg::OHM_BITS-1:0]   chan_ohms_r [2];
  logic [dpsw_pkg::OHM_BITS-1:0]   ohms_r, ohms_nxt;
  logic [dpsw_pkg::CODE_BITS-1:0]  code_r, code_nxt;
  logic [dpsw_pkg::FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [dpsw_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            chan_r, chan_nxt;
  logic                            ohms_we;
  logic [dpsw_pkg::OHM_BITS-1:0]   ohms_wdata;

  logic                            in_fire;
  logic                            out_fire;
  logic                            last_bit;
  logic                            above_max;
  logic                            below_min;
  logic                            div_start;
  logic [dpsw_pkg::OHM_BITS-1:0]   diff;
  dpsw_pkg::div_stat_t             div_stat;
  logic [dpsw_pkg::CODE_BITS-1:0]  div_q;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_SEND);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign last_bit  = (cnt_r == dpsw_pkg::CNT_W'(dpsw_pkg::FRAME_BITS - 1));

  // Range tests and the divider operand.
  assign above_max = (in_data.resistance > max_ohms_r);
  assign below_min = (in_data.resistance < min_ohms_r);
  assign diff      = max_ohms_r - in_data.resistance;

  dpsw_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .diff     (diff),
    .top      (max_ohms_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Sequencer: accept, convert, then shift out the frame.
  always_comb begin
    state_nxt  = state_r;
    ohms_nxt   = ohms_r;
    code_nxt   = code_r;
    frame_nxt  = frame_r;
    cnt_nxt    = cnt_r;
    chan_nxt   = chan_r;
    ohms_we    = 1'b0;
    ohms_wdata = in_data.resistance;
    div_start  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && !in_data.channel[1]) begin
          chan_nxt  = in_data.channel[0];
          cnt_nxt   = '0;
          state_nxt = ST_SEND;
          if (in_data.operation == dpsw_pkg::OP_RAW) begin
            code_nxt = in_data.raw_code;
            ohms_nxt = chan_ohms_r[in_data.channel[0]];
          end else if (above_max) begin
            code_nxt   = dpsw_pkg::CODE_ZERO;
            ohms_wdata = max_ohms_r;
            ohms_we    = 1'b1;
            ohms_nxt   = max_ohms_r;
          end else if (below_min) begin
            code_nxt   = dpsw_pkg::CODE_FULL;
            ohms_wdata = min_ohms_r;
            ohms_we    = 1'b1;
            ohms_nxt   = min_ohms_r;
          end else if (max_ohms_r == '0) begin
            // Zero full scale: only zero ohms reaches here, and no division is done.
            code_nxt = dpsw_pkg::CODE_ZERO;
            ohms_we  = 1'b1;
            ohms_nxt = in_data.resistance;
          end else begin
            ohms_we   = 1'b1;
            ohms_nxt  = in_data.resistance;
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
          frame_nxt = {in_data.channel[0], code_nxt};
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          code_nxt  = div_q;
          frame_nxt = {chan_r, div_q};
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_fire) begin
          frame_nxt = frame_r << 1;
          cnt_nxt   = cnt_r + dpsw_pkg::CNT_W'(1);
          if (last_bit) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state, configuration registers and the per-channel resistance store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      max_ohms_r     <= dpsw_pkg::MAX_OHMS_RESET;
      min_ohms_r     <= dpsw_pkg::MIN_OHMS_RESET;
      chan_ohms_r[0] <= '0;
      chan_ohms_r[1] <= '0;
      cnt_r          <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          dpsw_pkg::REG_MAX_OHMS: max_ohms_r <= cfg_wdata;
          dpsw_pkg::REG_MIN_OHMS: min_ohms_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (ohms_we) begin
        chan_ohms_r[in_data.channel[0]] <= ohms_wdata;
      end
    end
  end

  // Frame payload registers.
  always_ff @(posedge clk) begin
    ohms_r  <= ohms_nxt;
    code_r  <= code_nxt;
    frame_r <= frame_nxt;
    chan_r  <= chan_nxt;
  end

  // Output beat.
  assign out_data.serial_bit  = frame_r[dpsw_pkg::FRAME_BITS-1];
  assign out_data.frame_end   = last_bit;
  assign out_data.code_sent   = code_r;
  assign out_data.stored_ohms = ohms_r;

endmodule

// ----- src/dpsw_checker.sv -----
// Port-level checker for the digital potentiometer wiper writer, bound to the top level.
`include "digipot_resistance_spi_writer_assert.svh"

module dpsw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input dpsw_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input dpsw_pkg::out_beat_t out_data
);

  // The block never takes a command while a frame is being shifted out.
  `DPSW_ASSERT_NOW(a_no_accept_while_sending, in_ready, !out_valid)

  // The last beat of a frame closes it.
  `DPSW_ASSERT_NEXT(a_frame_closes, out_valid && out_ready && out_data.frame_end, !out_valid)

  // Within a frame the next bit follows at once and carries the same code.
  `DPSW_ASSERT_NEXT(a_code_steady, out_valid && out_ready && !out_data.frame_end,
                    out_valid && (out_data.code_sent == $past(out_data.code_sent)))

  // A command for a channel above one is dropped and the block stays free.
  `DPSW_ASSERT_NEXT(a_bad_channel_dropped, in_valid && in_ready && in_data.channel[1],
                    in_ready && !out_valid)

endmodule

bind digipot_resistance_spi_writer dpsw_checker u_dpsw_checker (.*);

// ----- bench/tb_digipot_resistance_spi_writer.sv -----
// Self-checking bench for the potentiometer writer: command stream in, framed wiper bits out.
module tb_digipot_resistance_spi_writer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_STALL = 300;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dpsw_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dpsw_pkg::out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [dpsw_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [dpsw_pkg::OHM_BITS-1:0] cfg_wdata = '0;

  // Commands waiting to be offered, and frame bits predicted but not yet seen.
  dpsw_pkg::in_beat_t cmd_q[$];
  dpsw_pkg::out_beat_t frame_bits_q[$];

  // Bench copy of the register file and the per-channel resistance store.
  logic [dpsw_pkg::OHM_BITS-1:0] max_ohms = dpsw_pkg::MAX_OHMS_RESET;
  logic [dpsw_pkg::OHM_BITS-1:0] min_ohms = dpsw_pkg::MIN_OHMS_RESET;
  logic [dpsw_pkg::OHM_BITS-1:0] chan_ohms[2] = '{default: '0};

  int unsigned cmds_offered = 0;
  int unsigned cmds_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned in_idle_pct = 29;
  int unsigned out_idle_pct = 29;
  int unsigned stall_asks = 0;
  int unsigned stall_seen = 0;
  int unsigned stall_left = 0;

  digipot_resistance_spi_writer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Work out the nine frame bits a command produces and queue them; a dropped channel queues none.
  function automatic void predict_frame(dpsw_pkg::in_beat_t cmd);
    logic [dpsw_pkg::CODE_BITS-1:0] code;
    logic [dpsw_pkg::FRAME_BITS-1:0] frame;
    longint unsigned top;
    longint unsigned req;
    dpsw_pkg::out_beat_t bit_exp;
    int unsigned ch;
    if (cmd.channel > 2'd1) return;
    ch = cmd.channel;
    top = max_ohms;
    req = cmd.resistance;
    if (cmd.operation == dpsw_pkg::OP_RAW) begin
      code = cmd.raw_code;
    end else if (cmd.resistance > max_ohms) begin
      code = dpsw_pkg::CODE_ZERO;
      chan_ohms[ch] = max_ohms;
    end else if (cmd.resistance < min_ohms) begin
      code = dpsw_pkg::CODE_FULL;
      chan_ohms[ch] = min_ohms;
    end else begin
      // Rounded half up: (510*(max-R) + max) / (2*max); a zero maximum gives code zero.
      if (top == 0) code = dpsw_pkg::CODE_ZERO;
      else code = dpsw_pkg::CODE_BITS'((510 * (top - req) + top) / (2 * top));
      chan_ohms[ch] = cmd.resistance;
    end
    frame = {cmd.channel[0], code};
    for (int k = 0; k < dpsw_pkg::FRAME_BITS; k++) begin
      bit_exp.serial_bit = frame[dpsw_pkg::FRAME_BITS-1-k];
      bit_exp.frame_end = (k == dpsw_pkg::FRAME_BITS - 1);
      bit_exp.code_sent = code;
      bit_exp.stored_ohms = chan_ohms[ch];
      frame_bits_q.push_back(bit_exp);
    end
  endfunction

  // Compare one received frame bit with the oldest prediction.
  function automatic void check_frame_bit(dpsw_pkg::out_beat_t got);
    dpsw_pkg::out_beat_t want;
    if (frame_bits_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected beat: bit %0d end %0d code %0d ohms %0d",
                 got.serial_bit, got.frame_end, got.code_sent, got.stored_ohms);
      return;
    end
    want = frame_bits_q.pop_front();
    if (got.serial_bit !== want.serial_bit || got.frame_end !== want.frame_end ||
        got.code_sent !== want.code_sent || got.stored_ohms !== want.stored_ohms) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display({"mismatch: expected bit %0d end %0d code %0d ohms %0d, ",
                  "got bit %0d end %0d code %0d ohms %0d"},
                 want.serial_bit, want.frame_end, want.code_sent, want.stored_ohms,
                 got.serial_bit, got.frame_end, got.code_sent, got.stored_ohms);
    end
  endfunction

  // Monitor: commands are predicted when taken, result beats checked when taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_frame(in_data);
        cmds_taken++;
      end
      if (out_valid && out_ready) check_frame_bit(out_data);
    end
  end

  // Cycle limit in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Driver: holds a beat until taken, otherwise offers the next command or idles.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && cmds_taken != cmds_offered) begin
      in_valid <= 1'b1;
    end else if (cmd_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
      in_data <= cmd_q.pop_front();
      in_valid <= 1'b1;
      cmds_offered++;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_seen != stall_asks) begin
        stall_seen = stall_asks;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  function automatic dpsw_pkg::in_beat_t make_cmd(logic op, logic [1:0] ch,
                                                  logic [dpsw_pkg::CODE_BITS-1:0] code,
                                                  logic [dpsw_pkg::OHM_BITS-1:0] ohms);
    dpsw_pkg::in_beat_t cmd;
    cmd.operation = op;
    cmd.channel = ch;
    cmd.raw_code = code;
    cmd.resistance = ohms;
    return cmd;
  endfunction

  // Random command, with resistances weighted toward the range and its edges.
  function automatic dpsw_pkg::in_beat_t random_cmd();
    dpsw_pkg::in_beat_t cmd;
    int unsigned pick;
    int unsigned lo;
    cmd.operation = $urandom_range(1) ? dpsw_pkg::OP_SET : dpsw_pkg::OP_RAW;
    cmd.channel = ($urandom_range(99) < 85) ? 2'($urandom_range(1)) : 2'($urandom_range(3, 2));
    cmd.raw_code = dpsw_pkg::CODE_BITS'($urandom);
    lo = (min_ohms <= max_ohms) ? min_ohms : max_ohms;
    pick = $urandom_range(99);
    if (pick < 50) cmd.resistance = dpsw_pkg::OHM_BITS'($urandom_range(max_ohms, lo));
    else if (pick < 60) cmd.resistance = max_ohms + dpsw_pkg::OHM_BITS'($urandom_range(1));
    else if (pick < 70) cmd.resistance = min_ohms - dpsw_pkg::OHM_BITS'($urandom_range(1));
    else if (pick < 85) cmd.resistance = dpsw_pkg::OHM_BITS'($urandom);
    else cmd.resistance = dpsw_pkg::OHM_BITS'($urandom_range(lo));
    return cmd;
  endfunction

  task automatic write_reg(input logic [dpsw_pkg::REG_IDX_W-1:0] idx,
                           input logic [dpsw_pkg::OHM_BITS-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == dpsw_pkg::REG_MAX_OHMS) max_ohms = val;
    else if (idx == dpsw_pkg::REG_MIN_OHMS) min_ohms = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Wait until every command is taken and every frame bit has arrived, then let
  // dropped commands and the divider settle.
  task automatic wait_drained();
    @(negedge clk);
    while (cmd_q.size() != 0 || cmds_taken != cmds_offered || frame_bits_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_range(input logic [dpsw_pkg::OHM_BITS-1:0] top,
                           input logic [dpsw_pkg::OHM_BITS-1:0] bottom);
    wait_drained();
    write_reg(dpsw_pkg::REG_MAX_OHMS, top);
    write_reg(dpsw_pkg::REG_MIN_OHMS, bottom);
  endtask

  initial begin
    int unsigned top;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: raw writes, in-range and above-maximum conversions, dropped channels, at reset settings.
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_RAW, 2'd0, 8'h00, 20'h00000));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_RAW, 2'd1, 8'hFF, 20'hFFFFF));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd0, 8'h00, 20'd0));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd1, 8'h00, 20'd20000));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd0, 8'hFF, 20'd10000));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd1, 8'h00, 20'd20001));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_RAW, 2'd1, 8'hA5, 20'd5));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd0, 8'h5A, 20'hFFFFF));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd2, 8'h00, 20'd100));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_RAW, 2'd3, 8'h11, 20'd0));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_RAW, 2'd0, 8'h5A, 20'hAAAAA));

    // Below the minimum clamps to full code and stores the minimum.
    set_range(20'd20000, 20'd5000);
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd0, 8'h00, 20'd4999));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd1, 8'h00, 20'd5000));

    // Zero maximum: the in-range case must not divide.
    set_range(20'd0, 20'd0);
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd0, 8'h00, 20'd0));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd1, 8'h00, 20'd1));

    // Minimum above maximum: the above-maximum test wins.
    set_range(20'd100, 20'd200);
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd0, 8'h00, 20'd150));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd1, 8'h00, 20'd50));

    // Extremes of both registers.
    set_range(20'd1, 20'd0);
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd0, 8'h00, 20'd0));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd1, 8'h00, 20'd1));
    set_range(20'hFFFFF, 20'hFFFFF);
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd0, 8'h00, 20'hFFFFF));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd1, 8'h00, 20'hFFFFE));
    set_range(20'hFFFFF, 20'd0);
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd0, 8'h00, 20'd1));
    cmd_q.push_back(make_cmd(dpsw_pkg::OP_SET, 2'd1, 8'h00, 20'hFFFFF));

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_range(20'd20000, 20'd0);
        1: set_range(20'd1000, 20'd250);
        2: set_range(20'd65535, 20'd65535);
        3: set_range(20'd777777, 20'd12345);
        default: begin
          top = $urandom_range(20'hFFFFF, 1);
          set_range(dpsw_pkg::OHM_BITS'(top), dpsw_pkg::OHM_BITS'($urandom_range(top)));
        end
      endcase
      // One phase with no idling on either side.
      in_idle_pct = (ph == 2) ? 0 : 29;
      out_idle_pct = (ph == 2) ? 0 : 29;
      // The receiver holds off while commands keep coming.
      if (ph == 3) stall_asks++;
      repeat (13) cmd_q.push_back(random_cmd());
      // The sender waits for every frame to come out before going on.
      if (ph == 1) wait_drained();
      repeat (13) cmd_q.push_back(random_cmd());
    end

    wait_drained();
    if (mismatches == 0 && frame_bits_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/dpsw_pkg.sv
src/dpsw_divider.sv
src/digipot_resistance_spi_writer.sv
src/dpsw_checker.sv
bench/tb_digipot_resistance_spi_writer.sv
